>>> design/brf_pkg.sv
package brf_pkg;

    // Operation codes carried in the op field of an input transaction.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_SKIP  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int AMOUNT_W = 9;
    localparam int SIZE_W   = 9;
    localparam int COUNT_W  = 8;

    localparam int DEPTH_DEFAULT = 256;
    localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 9'd256;

endpackage

>>> design/brf_if.sv
interface brf_in_if;
    logic                             valid;
    logic                             ready;
    logic [brf_pkg::OP_W-1:0]         op;
    logic [brf_pkg::BYTE_W-1:0]       data_in;
    logic [brf_pkg::AMOUNT_W-1:0]     amount;

    modport source (output valid, output op, output data_in, output amount, input ready);
    modport sink   (input valid, input op, input data_in, input amount, output ready);
endinterface

interface brf_out_if;
    logic                             valid;
    logic                             ready;
    logic [brf_pkg::BYTE_W-1:0]       data_out;
    logic                             ok;
    logic [brf_pkg::COUNT_W-1:0]      used_count;
    logic [brf_pkg::COUNT_W-1:0]      free_count;

    modport source (output valid, output data_out, output ok, output used_count,
                    output free_count, input ready);
    modport sink   (input valid, input data_out, input ok, input used_count,
                    input free_count, output ready);
endinterface

interface brf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [brf_pkg::SIZE_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds its value until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/byte_ring_fifo_with_peek.sv
// Byte ring FIFO with peek and skip, one result transaction per input transaction.
// A result passes through stage one, which holds the registered memory read,
// and then through the output register before it is valid.
// Throughput: one transaction per cycle while the output side keeps up.
// Reset: rst_n clears both pointers, the pipeline valid bits and sets ring_size
// to 256; the byte store itself is not cleared and needs no clearing pass.
module byte_ring_fifo_with_peek #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    brf_cfg_if.sink   cfg,
    brf_in_if.sink    in_ch,
    brf_out_if.source out_ch
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Size arithmetic must hold both the 9-bit register and DEPTH itself.
    localparam int SW = (PW + 1 > brf_pkg::SIZE_W) ? PW + 1 : brf_pkg::SIZE_W;

    // Architectural state: ring size register and the two pointers. Both
    // pointers always stay below the effective size, so no wrap is needed
    // when they are read.
    logic [brf_pkg::SIZE_W-1:0] ring_size_reg;
    logic [PW-1:0]              head_reg, head_next;
    logic [PW-1:0]              tail_reg, tail_next;

    // Stage one holds everything about the accepted transaction except the
    // byte, which arrives from the memory in the cycle after the read is issued.
    logic                        s1_valid_reg;
    logic                        s1_ok_reg, s1_ok_next;
    logic                        s1_rd_reg, s1_rd_next;
    logic [brf_pkg::COUNT_W-1:0] s1_used_reg, s1_used_next;
    logic [brf_pkg::COUNT_W-1:0] s1_free_reg, s1_free_next;

    // Output register, which lets the next transaction enter while a result
    // waits for the consumer.
    logic                        out_valid_reg;
    logic [brf_pkg::BYTE_W-1:0]  out_data_reg;
    logic                        out_ok_reg;
    logic [brf_pkg::COUNT_W-1:0] out_used_reg;
    logic [brf_pkg::COUNT_W-1:0] out_free_reg;

    logic                        s1_advance;
    logic                        in_fire;
    logic                        cfg_fire;

    logic [SW-1:0]               rs_ext;
    logic [SW-1:0]               size_eff;
    logic [SW-1:0]               h_ext;
    logic [SW-1:0]               t_ext;
    logic [SW-1:0]               used;
    logic [SW-1:0]               used_new;
    logic [SW-1:0]               amt_ext;
    logic [SW-1:0]               h_plus_amt;
    logic [SW-1:0]               h_plus_amt_wrap;
    logic [SW-1:0]               h_inc;
    logic [SW-1:0]               t_inc;
    logic [SW-1:0]               free_new;

    logic                        ram_we;
    logic                        ram_re;
    logic [PW-1:0]               ram_raddr;
    logic [brf_pkg::BYTE_W-1:0]  ram_rdata;

    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid;

    // Stage one moves on whenever the output register is empty or being drained.
    assign s1_advance  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Effective ring size: the register clamped to the range 2..DEPTH.
    assign rs_ext = SW'(ring_size_reg);
    always_comb
    begin
        priority if (rs_ext < SW'(2))
        begin
            size_eff = SW'(2);
        end
        else if (rs_ext > SW'(DEPTH))
        begin
            size_eff = SW'(DEPTH);
        end
        else
        begin
            size_eff = rs_ext;
        end
    end

    assign h_ext   = SW'(head_reg);
    assign t_ext   = SW'(tail_reg);
    assign amt_ext = SW'(in_ch.amount);

    // Number of bytes held before this transaction.
    assign used = (t_ext >= h_ext) ? (t_ext - h_ext) : (size_eff - h_ext + t_ext);

    // Peek and skip offsets are bounded by the held count, so head plus the
    // offset stays below twice the size and one subtract wraps it.
    assign h_plus_amt      = h_ext + amt_ext;
    assign h_plus_amt_wrap = (h_plus_amt >= size_eff) ? (h_plus_amt - size_eff) : h_plus_amt;
    assign h_inc           = (h_ext + SW'(1) == size_eff) ? '0 : h_ext + SW'(1);
    assign t_inc           = (t_ext + SW'(1) == size_eff) ? '0 : t_ext + SW'(1);

    // Decode of the accepted transaction: pointer updates, memory access and
    // the status fields that go with the result.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        used_new   = used;
        s1_ok_next = 1'b0;
        s1_rd_next = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = head_reg;
        unique case (in_ch.op)
            brf_pkg::OP_PUSH:
            begin
                if (used < size_eff - SW'(1))
                begin
                    ram_we     = in_fire;
                    tail_next  = PW'(t_inc);
                    used_new   = used + SW'(1);
                    s1_ok_next = 1'b1;
                end
            end
            brf_pkg::OP_POP:
            begin
                if (used != '0)
                begin
                    ram_re     = in_fire;
                    s1_rd_next = 1'b1;
                    head_next  = PW'(h_inc);
                    used_new   = used - SW'(1);
                    s1_ok_next = 1'b1;
                end
            end
            brf_pkg::OP_PEEK:
            begin
                if (amt_ext < used)
                begin
                    ram_re     = in_fire;
                    ram_raddr  = PW'(h_plus_amt_wrap);
                    s1_rd_next = 1'b1;
                    s1_ok_next = 1'b1;
                end
            end
            brf_pkg::OP_SKIP:
            begin
                if (amt_ext > used)
                begin
                    // Skipping past the held bytes empties the ring and fails.
                    head_next = tail_reg;
                    used_new  = '0;
                end
                else
                begin
                    head_next  = PW'(h_plus_amt_wrap);
                    used_new   = used - amt_ext;
                    s1_ok_next = 1'b1;
                end
            end
            brf_pkg::OP_CLEAR:
            begin
                head_next  = tail_reg;
                used_new   = '0;
                s1_ok_next = 1'b1;
            end
            default:
            begin
                // Unused op codes change nothing and report failure.
                s1_ok_next = 1'b0;
            end
        endcase
    end

    assign free_new     = size_eff - SW'(1) - used_new;
    assign s1_used_next = brf_pkg::COUNT_W'(used_new);
    assign s1_free_next = brf_pkg::COUNT_W'(free_new);

    // The byte store. A push writes at the tail at the acceptance edge; a
    // later pop or peek of the same slot is issued at a later edge, so the
    // write has always landed before the read samples the array.
    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (in_ch.data_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointer and ring size state. A ring size write empties the ring; the user
    // must issue it only while no transaction is in flight. The block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= brf_pkg::RING_SIZE_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else if (cfg_fire)
        begin
            ring_size_reg <= cfg.data;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else if (in_fire)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ok_reg   <= s1_ok_next;
            s1_rd_reg   <= s1_rd_next;
            s1_used_reg <= s1_used_next;
            s1_free_reg <= s1_free_next;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_data_reg <= s1_rd_reg ? ram_rdata : '0;
            out_ok_reg   <= s1_ok_reg;
            out_used_reg <= s1_used_reg;
            out_free_reg <= s1_free_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.data_out   = out_data_reg;
    assign out_ch.ok         = out_ok_reg;
    assign out_ch.used_count = out_used_reg;
    assign out_ch.free_count = out_free_reg;

endmodule

>>> tb/byte_ring_fifo_with_peek_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the byte ring FIFO. A driver streams operations
// from a queue that the initial block fills, a shadow ring predicts every
// response at the moment its request transaction is accepted, and a monitor
// compares each response transaction against the oldest prediction.
module byte_ring_fifo_with_peek_tb;

    // The block answers through its stage one and output registers, so a short
    // tail after the last response is enough to catch anything extra.
    localparam int RESP_LATENCY = 2;
    localparam int TAIL_CYCLES  = RESP_LATENCY + 8;
    localparam int CYCLE_LIMIT  = 200000;

    // One request transaction as the driver presents it. The drain flag makes
    // the driver hold the request back until every outstanding response has
    // come back, which puts the block through a fully idle pipeline mid-phase.
    typedef struct {
        logic [brf_pkg::OP_W-1:0]     op;
        logic [brf_pkg::BYTE_W-1:0]   data_in;
        logic [brf_pkg::AMOUNT_W-1:0] amount;
        bit                           drain;
    } ring_req_t;

    // One response transaction, field for field as it appears on the port.
    typedef struct {
        logic [brf_pkg::BYTE_W-1:0]  data_out;
        logic                        ok;
        logic [brf_pkg::COUNT_W-1:0] used_count;
        logic [brf_pkg::COUNT_W-1:0] free_count;
    } ring_status_t;

    logic clk = 1'b0;
    logic rst_n;

    brf_cfg_if cfg_bus ();
    brf_in_if  in_bus ();
    brf_out_if out_bus ();

    byte_ring_fifo_with_peek u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    always #5ns clk = ~clk;

    // Requests waiting to be driven, and the responses the shadow ring says
    // the block owes us, oldest first.
    ring_req_t    pending_reqs[$];
    ring_status_t predicted_status[$];

    // Shadow copy of the ring: byte store, read and write pointers and the
    // size register. Only bytes that were pushed are ever read back.
    logic [brf_pkg::BYTE_W-1:0] shadow_mem [brf_pkg::DEPTH_DEFAULT];
    int unsigned                shadow_rd;
    int unsigned                shadow_wr;
    logic [brf_pkg::SIZE_W-1:0] shadow_size;

    int err_count;
    int cycle_count;

    // Driver and monitor bookkeeping.
    ring_req_t cur_req;
    bit        req_busy;
    int        send_gap;
    bit        send_quiet;
    int        recv_stall;
    bit        recv_quiet;

    // The size register is clamped to 2..DEPTH before it is used.
    function automatic int unsigned clamp_size(input logic [brf_pkg::SIZE_W-1:0] v);
        if (v < 2)
        begin
            return 2;
        end
        if (v > brf_pkg::DEPTH_DEFAULT)
        begin
            return brf_pkg::DEPTH_DEFAULT;
        end
        return v;
    endfunction

    // Number of bytes between the read and write pointers for a ring of s slots.
    function automatic int unsigned held_bytes(input int unsigned s);
        return (shadow_wr >= shadow_rd) ? (shadow_wr - shadow_rd) : (s - shadow_rd + shadow_wr);
    endfunction

    // Applies one request to the shadow ring and returns the response the
    // block must produce for it. One slot is always left unused, so a ring of
    // s slots holds at most s-1 bytes.
    function automatic ring_status_t ring_apply(input ring_req_t req);
        int unsigned  s;
        int unsigned  used;
        ring_status_t st;
        s = clamp_size(shadow_size);
        shadow_rd = shadow_rd % s;
        shadow_wr = shadow_wr % s;
        used = held_bytes(s);
        st.data_out = '0;
        st.ok = 1'b0;
        case (req.op)
            brf_pkg::OP_PUSH:
            begin
                // A byte that does not fit is dropped.
                if (used < s - 1)
                begin
                    shadow_mem[shadow_wr] = req.data_in;
                    shadow_wr = (shadow_wr + 1) % s;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::OP_POP:
            begin
                if (used > 0)
                begin
                    st.data_out = shadow_mem[shadow_rd];
                    shadow_rd = (shadow_rd + 1) % s;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::OP_PEEK:
            begin
                if (req.amount < used)
                begin
                    st.data_out = shadow_mem[(shadow_rd + req.amount) % s];
                    st.ok = 1'b1;
                end
            end
            brf_pkg::OP_SKIP:
            begin
                // Skipping past the held bytes empties the ring and fails.
                if (req.amount > used)
                begin
                    shadow_rd = shadow_wr;
                end
                else
                begin
                    shadow_rd = (shadow_rd + req.amount) % s;
                    st.ok = 1'b1;
                end
            end
            brf_pkg::OP_CLEAR:
            begin
                shadow_rd = shadow_wr;
                st.ok = 1'b1;
            end
            default:
            begin
                // Unused opcodes leave the ring alone and report failure.
            end
        endcase
        used = held_bytes(s);
        st.used_count = used[brf_pkg::COUNT_W-1:0];
        st.free_count = brf_pkg::COUNT_W'(s - 1 - used);
        return st;
    endfunction

    task automatic check_field(input string name, input logic [8:0] exp_v,
                               input logic [8:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic queue_req(input logic [brf_pkg::OP_W-1:0] op,
                             input logic [brf_pkg::BYTE_W-1:0] data_in,
                             input logic [brf_pkg::AMOUNT_W-1:0] amount);
        ring_req_t req;
        req.op = op;
        req.data_in = data_in;
        req.amount = amount;
        req.drain = 1'b0;
        pending_reqs.push_back(req);
    endtask

    // Waits until nothing is queued, nothing is on the request port and no
    // response is outstanding, then lets the pipeline settle.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_busy || predicted_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Writes the size register. The block empties the ring on this write, so
    // the shadow pointers are reset at the same clock edge.
    task automatic write_ring_size(input logic [brf_pkg::SIZE_W-1:0] v);
        @(posedge clk);
        cfg_bus.data <= v;
        cfg_bus.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        shadow_size = v;
        shadow_rd = 0;
        shadow_wr = 0;
        cfg_bus.valid <= 1'b0;
    endtask

    // One phase: reprogram the ring size while idle, then queue a pop (which
    // must fail since the write emptied the ring) and a run of random requests.
    // push_pct and pop_pct steer the fill level; the rest are peeks, skips,
    // clears and unused opcodes. The middle request of each phase waits for
    // the block to drain completely before it is sent.
    task automatic run_phase(input logic [brf_pkg::SIZE_W-1:0] size, input int count,
                             input int push_pct, input int pop_pct);
        int unsigned s;
        int          pick;
        int          sub;
        ring_req_t   req;
        wait_idle();
        write_ring_size(size);
        s = clamp_size(size);
        queue_req(brf_pkg::OP_POP, brf_pkg::BYTE_W'($urandom),
                  brf_pkg::AMOUNT_W'($urandom));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            req.data_in = brf_pkg::BYTE_W'($urandom);
            req.amount = brf_pkg::AMOUNT_W'($urandom_range(0, (1 << brf_pkg::AMOUNT_W) - 1));
            req.drain = (i == count / 2);
            if (pick < push_pct)
            begin
                req.op = brf_pkg::OP_PUSH;
            end
            else if (pick < push_pct + pop_pct)
            begin
                req.op = brf_pkg::OP_POP;
            end
            else if (sub < 50)
            begin
                // Peek offsets mostly fall around the fill level of the ring.
                req.op = brf_pkg::OP_PEEK;
                if (sub < 35)
                begin
                    req.amount = brf_pkg::AMOUNT_W'($urandom_range(0, s));
                end
                else if (sub < 45)
                begin
                    req.amount = brf_pkg::AMOUNT_W'($urandom_range(0, 3));
                end
            end
            else if (sub < 80)
            begin
                // Skips are kept short most of the time so the ring stays busy.
                req.op = brf_pkg::OP_SKIP;
                if (sub < 68)
                begin
                    req.amount = brf_pkg::AMOUNT_W'($urandom_range(0, 2));
                end
                else if (sub < 77)
                begin
                    req.amount = brf_pkg::AMOUNT_W'($urandom_range(0, s));
                end
            end
            else if (sub < 92)
            begin
                req.op = brf_pkg::OP_CLEAR;
            end
            else
            begin
                req.op = brf_pkg::OP_W'($urandom_range(brf_pkg::OP_CLEAR + 1,
                                                       (1 << brf_pkg::OP_W) - 1));
            end
            pending_reqs.push_back(req);
        end
    endtask

    // Request driver. A transaction completes at an edge where valid and
    // ready are both high; the shadow ring is advanced right there, so the
    // prediction follows the exact order in which the block sees requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
            in_bus.op <= brf_pkg::OP_PUSH;
            in_bus.data_in <= '0;
            in_bus.amount <= '0;
            req_busy = 1'b0;
            send_gap = 0;
            send_quiet = 1'b0;
        end
        else
        begin
            if (req_busy && in_bus.ready)
            begin
                predicted_status.push_back(ring_apply(cur_req));
                req_busy = 1'b0;
                // Every so often switch between bursty and back-to-back sending.
                if ($urandom_range(0, 29) == 0)
                begin
                    send_quiet = !send_quiet;
                end
                send_gap = send_quiet ? 0 : $urandom_range(0, 9);
            end
            if (!req_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && predicted_status.size() != 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    req_busy = 1'b1;
                    in_bus.op <= cur_req.op;
                    in_bus.data_in <= cur_req.data_in;
                    in_bus.amount <= cur_req.amount;
                end
            end
            in_bus.valid <= req_busy;
        end
    end

    // Response monitor. It drops ready for a random number of cycles after
    // each transaction, with occasional stretches where it never stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            recv_stall = 0;
            recv_quiet = 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    $error("response transaction arrived with no request outstanding");
                    err_count++;
                end
                else
                begin
                    ring_status_t exp_st;
                    exp_st = predicted_status.pop_front();
                    check_field("data_out", 9'(exp_st.data_out), 9'(out_bus.data_out));
                    check_field("ok", 9'(exp_st.ok), 9'(out_bus.ok));
                    check_field("used_count", 9'(exp_st.used_count),
                                9'(out_bus.used_count));
                    check_field("free_count", 9'(exp_st.free_count),
                                9'(out_bus.free_count));
                end
                if ($urandom_range(0, 29) == 0)
                begin
                    recv_quiet = !recv_quiet;
                end
                recv_stall = recv_quiet ? 0 : $urandom_range(0, 9);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        err_count = 0;
        cycle_count = 0;
        shadow_rd = 0;
        shadow_wr = 0;
        shadow_size = brf_pkg::RING_SIZE_RESET;
        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks at the reset size of 256 slots: the empty ring,
        // a few held bytes with peeks inside and past the fill level, skips
        // of zero, of part of what is held and of more than is held, the unused
        // opcodes, and clear. One byte is left held on purpose so that the
        // following size write has something to throw away.
        queue_req(brf_pkg::OP_POP, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_PEEK, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_SKIP, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_SKIP, 8'h00, 9'd1);
        queue_req(brf_pkg::OP_PUSH, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_PUSH, 8'hFF, 9'h1FF);
        queue_req(brf_pkg::OP_PUSH, 8'hA5, 9'd0);
        queue_req(brf_pkg::OP_PUSH, 8'h5A, 9'd0);
        queue_req(brf_pkg::OP_PEEK, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_PEEK, 8'h00, 9'd3);
        queue_req(brf_pkg::OP_PEEK, 8'h00, 9'd4);
        queue_req(brf_pkg::OP_PEEK, 8'hFF, 9'd256);
        queue_req(brf_pkg::OP_SKIP, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_POP, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_SKIP, 8'h00, 9'd2);
        queue_req(brf_pkg::OP_SKIP, 8'h00, 9'd256);
        queue_req(brf_pkg::OP_PUSH, 8'h3C, 9'd0);
        queue_req(brf_pkg::OP_CLEAR + 3'd1, 8'hFF, 9'h1FF);
        queue_req(brf_pkg::OP_CLEAR + 3'd2, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_CLEAR + 3'd3, 8'hFF, 9'h1FF);
        queue_req(brf_pkg::OP_CLEAR, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_POP, 8'h00, 9'd0);
        queue_req(brf_pkg::OP_PUSH, 8'hC3, 9'd0);

        // Sizes below the minimum clamp to two slots (one usable byte).
        run_phase(9'd0, 60, 40, 30);
        run_phase(9'd1, 30, 50, 20);
        run_phase(9'd2, 60, 40, 30);
        run_phase(9'd3, 60, 45, 25);
        for (int i = 0; i < 3; i++)
        begin
            run_phase(brf_pkg::SIZE_W'($urandom_range(4, 16)), 40,
                      $urandom_range(30, 60), $urandom_range(20, 35));
        end
        // Full size, mostly pushes, so the ring fills toward its 255-byte limit.
        run_phase(9'd256, 340, 95, 2);
        // Sizes above the maximum clamp to the full store.
        run_phase(9'h1FF, 50, 40, 40);
        run_phase(brf_pkg::SIZE_W'($urandom_range(17, 255)), 50, 50, 30);
        run_phase(brf_pkg::SIZE_W'($urandom_range(257, 510)), 40, 45, 30);

        wait_idle();
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> byte_ring_fifo_with_peek.f
design/brf_pkg.sv
design/brf_if.sv
design/brf_ram.sv
design/byte_ring_fifo_with_peek.sv
tb/byte_ring_fifo_with_peek_tb.sv
